>>> rtl/core/ulisr_pkg.sv
// ----------------------------------------------------------------------------
// ulisr_pkg
// Types, codes and constants shared by the unsorted list engine and its cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ulisr_pkg;

  localparam int Capacity = 16;
  localparam int KeyW     = 32;
  localparam int LocW     = 4;
  localparam int FillW    = 5;

  typedef logic [1:0] cmd_t;
  localparam cmd_t CmdInsert = 2'd0;
  localparam cmd_t CmdSearch = 2'd1;
  localparam cmd_t CmdRemove = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t StatOk      = 2'd0;
  localparam status_t StatFull    = 2'd1;
  localparam status_t StatEmpty   = 2'd2;
  localparam status_t StatMissing = 2'd3;

  typedef enum logic [2:0] {
    StIdle,
    StExec,
    StScan,
    StShift,
    StDone
  } state_e;

  typedef struct packed {
    cmd_t                   cmd;
    logic signed [KeyW-1:0] key;
  } req_t;

  typedef struct packed {
    status_t          status;
    logic [LocW-1:0]  location;
    logic [FillW-1:0] fill_after;
  } rsp_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic                   load;
    logic                   run;
    logic                   shift;
    logic signed [KeyW-1:0] key;
  } cell_ctl_t;

endpackage

>>> rtl/core/ulisr_cell.sv
// ----------------------------------------------------------------------------
// ulisr_cell
// One list slot: holds a key, compares it while the scan token sits here,
// and takes its right neighbor's key when the list closes a gap.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ulisr_cell #(
  parameter int Index = 0,
  parameter int IdxW  = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ulisr_pkg::cell_ctl_t            ctl_i,
  input  logic [IdxW-1:0]                 pos_i,
  input  logic                            token_i,
  input  logic signed [ulisr_pkg::KeyW-1:0] next_data_i,
  output logic                            token_o,
  output logic signed [ulisr_pkg::KeyW-1:0] data_o,
  output logic                            hit_o
);

  localparam logic [IdxW-1:0] MyIdx = IdxW'(Index);

  logic signed [ulisr_pkg::KeyW-1:0] data_q, data_d;
  logic                              token_q, token_d;

  always_comb begin
    data_d = data_q;
    if (ctl_i.load && (pos_i == MyIdx)) begin
      data_d = ctl_i.key;
    end else if (ctl_i.shift && (MyIdx >= pos_i)) begin
      data_d = next_data_i;
    end
  end

  // token walks one cell per cycle while the scan runs
  assign token_d = ctl_i.run ? token_i : 1'b0;

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      token_q <= 1'b0;
    end else begin
      token_q <= token_d;
    end
  end

  assign token_o = token_q;
  assign data_o  = data_q;
  assign hit_o   = token_q && (data_q == ctl_i.key);

endmodule

>>> rtl/core/unsorted_list_insert_search_remove.sv
// ----------------------------------------------------------------------------
// unsorted_list_insert_search_remove
// Sequence: a request is accepted in StIdle and decoded in StExec; search and
//   remove on a non-empty list scan in StScan up to position fill - 1, a remove
//   that hits closes the gap in StShift; StDone waits for a free output slot.
// Throughput: one transaction at a time; the scan token steps one cell a cycle
//   and the next request is taken in the same cycle the result appears.
// Reset: fill count and control clear at once; stored keys are left as is.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module unsorted_list_insert_search_remove #(
  parameter int CAPACITY = ulisr_pkg::Capacity
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  ulisr_pkg::req_t in_req_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output ulisr_pkg::rsp_t out_rsp_o
);

  localparam int IdxW  = $clog2(CAPACITY);
  localparam int FillW = $clog2(CAPACITY + 1);
  localparam logic [FillW-1:0] CapFill = FillW'(CAPACITY);

  ulisr_pkg::state_e  state_q, state_d;
  ulisr_pkg::req_t    req_q, req_d;
  ulisr_pkg::status_t status_q, status_d;
  ulisr_pkg::rsp_t    out_q, out_d;
  logic [IdxW-1:0]    idx_q, idx_d;
  logic [FillW-1:0]   fill_q, fill_d;
  logic               out_valid_q, out_valid_d;

  ulisr_pkg::cell_ctl_t ctl;
  logic [IdxW-1:0]      pos;
  logic                 start;
  logic                 accept;
  logic                 slot_free;
  logic                 any_hit;
  logic                 last_pos;
  logic [31:0]          loc_w;
  logic [31:0]          fill_w;

  logic [CAPACITY-1:0]  tok_in;
  logic [CAPACITY-1:0]  tokens;
  logic [CAPACITY-1:0]  hits;
  logic signed [ulisr_pkg::KeyW-1:0] data   [CAPACITY];
  logic signed [ulisr_pkg::KeyW-1:0] next_d [CAPACITY];

  // ---------------- cell chain ----------------
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign tok_in[i] = start;
    end else begin : g_link
      assign tok_in[i] = tokens[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign next_d[i] = data[i];
    end else begin : g_next
      assign next_d[i] = data[i+1];
    end

    ulisr_cell #(
      .Index (i),
      .IdxW  (IdxW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .pos_i       (pos),
      .token_i     (tok_in[i]),
      .next_data_i (next_d[i]),
      .token_o     (tokens[i]),
      .data_o      (data[i]),
      .hit_o       (hits[i])
    );
  end

  // only the token cell can report a hit
  assign any_hit   = |hits;
  assign last_pos  = (FillW'(idx_q) + FillW'(1)) == fill_q;
  assign accept    = in_valid_i && !in_stall_o;
  assign slot_free = !out_valid_q || !out_stall_i;
  assign loc_w     = 32'(idx_q);
  assign fill_w    = 32'(fill_q);

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ulisr_pkg::StIdle: begin
        if (accept) begin
          state_d = ulisr_pkg::StExec;
        end
      end
      ulisr_pkg::StExec: begin
        if (((req_q.cmd == ulisr_pkg::CmdSearch) || (req_q.cmd == ulisr_pkg::CmdRemove))
            && (fill_q != '0)) begin
          state_d = ulisr_pkg::StScan;
        end else begin
          state_d = ulisr_pkg::StDone;
        end
      end
      ulisr_pkg::StScan: begin
        if (any_hit) begin
          state_d = (req_q.cmd == ulisr_pkg::CmdRemove) ? ulisr_pkg::StShift
                                                       : ulisr_pkg::StDone;
        end else if (last_pos) begin
          state_d = ulisr_pkg::StDone;
        end
      end
      ulisr_pkg::StShift: begin
        state_d = ulisr_pkg::StDone;
      end
      ulisr_pkg::StDone: begin
        if (slot_free) begin
          state_d = ulisr_pkg::StIdle;
        end
      end
      default: begin
        state_d = ulisr_pkg::StIdle;
      end
    endcase
  end

  // ---------------- outputs and datapath ----------------
  always_comb begin
    ctl.load    = 1'b0;
    ctl.run     = 1'b0;
    ctl.shift   = 1'b0;
    ctl.key     = req_q.key;
    start       = 1'b0;
    pos         = fill_q[IdxW-1:0];
    req_d       = req_q;
    status_d    = status_q;
    idx_d       = idx_q;
    fill_d      = fill_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    case (state_q)
      ulisr_pkg::StIdle: begin
        if (accept) begin
          req_d    = in_req_i;
          status_d = ulisr_pkg::StatOk;
          idx_d    = '0;
        end
      end
      ulisr_pkg::StExec: begin
        case (req_q.cmd)
          ulisr_pkg::CmdInsert: begin
            if (fill_q < CapFill) begin
              ctl.load = 1'b1;
              idx_d    = fill_q[IdxW-1:0];
              fill_d   = fill_q + FillW'(1);
            end else begin
              status_d = ulisr_pkg::StatFull;
            end
          end
          ulisr_pkg::CmdSearch: begin
            if (fill_q == '0) begin
              status_d = ulisr_pkg::StatMissing;
            end else begin
              start   = 1'b1;
              ctl.run = 1'b1;
            end
          end
          ulisr_pkg::CmdRemove: begin
            if (fill_q == '0) begin
              status_d = ulisr_pkg::StatEmpty;
            end else begin
              start   = 1'b1;
              ctl.run = 1'b1;
            end
          end
          default: begin
            // undefined command leaves the list alone
          end
        endcase
      end
      ulisr_pkg::StScan: begin
        if (any_hit) begin
          // idx_q already points at the first match
        end else if (last_pos) begin
          status_d = ulisr_pkg::StatMissing;
          idx_d    = '0;
        end else begin
          ctl.run = 1'b1;
          idx_d   = idx_q + IdxW'(1);
        end
      end
      ulisr_pkg::StShift: begin
        ctl.shift = 1'b1;
        pos       = idx_q;
        fill_d    = fill_q - FillW'(1);
      end
      ulisr_pkg::StDone: begin
        if (slot_free) begin
          out_valid_d      = 1'b1;
          out_d.status     = status_q;
          out_d.location   = loc_w[ulisr_pkg::LocW-1:0];
          out_d.fill_after = fill_w[ulisr_pkg::FillW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ulisr_pkg::StIdle;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    status_q <= status_d;
    idx_q    <= idx_d;
    out_q    <= out_d;
  end

  assign in_stall_o  = (state_q != ulisr_pkg::StIdle);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CapFill)
    else $error("fill count above capacity");

  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tokens))
    else $error("more than one scan token in the chain");

  a_token_at_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ulisr_pkg::StScan) |-> tokens[idx_q])
    else $error("scan token not at the scan index");

  a_no_token_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ulisr_pkg::StScan) |-> (tokens == '0))
    else $error("scan token left behind outside a scan");
`endif

endmodule
